[rtl/rld_pkg.sv]
// Shared constants and control/status types of the run-length control byte decoder.
package rld_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned COUNT_W = 7;
  localparam int unsigned TOTAL_W = 17;

  // A repeat run emits at most this many bytes.
  localparam logic [COUNT_W-1:0] RESULT_LIMIT = COUNT_W'(64);
  localparam logic [TOTAL_W-1:0] TOTAL_MAX    = {TOTAL_W{1'b1}};
  localparam logic [TOTAL_W-1:0] TOTAL_CELLS_RESET = TOTAL_W'(4096);

  // Bit of a control byte that selects a repeat run.
  localparam int unsigned REPEAT_BIT = 7;

  typedef struct packed {
    logic load_count;    // latch the count of a control byte
    logic load_value;    // latch a repeat value and clip the count
    logic push_literal;  // send the input byte to the output register
    logic push_repeat;   // send the held repeat value to the output register
  } rld_cmd_t;

  typedef struct packed {
    logic slot_free;        // output register can take a byte this cycle
    logic byte_repeat;      // input byte has the repeat flag set
    logic byte_count_zero;  // input byte carries a zero count
    logic rem_zero;         // remaining count is zero
    logic rem_is_one;       // remaining count is one
  } rld_sts_t;

endpackage

[rtl/rld_in_if.sv]
// Input byte channel of the run-length decoder.
interface rld_in_if import rld_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

[rtl/rld_out_if.sv]
// Decoded byte channel of the run-length decoder.
interface rld_out_if import rld_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              last;
  logic              image_done;

  modport source (output valid, output out_byte, output last, output image_done, input ready);
  modport sink (input valid, input out_byte, input last, input image_done, output ready);
endinterface

[rtl/rld_cfg_if.sv]
// Configuration write channel of the run-length decoder.
interface rld_cfg_if import rld_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [TOTAL_W-1:0] total_cells;

  modport source (output valid, output total_cells, input ready);
  modport sink (input valid, input total_cells, output ready);
endinterface

[rtl/rld_ctrl.sv]
// Phase state machine of the run-length decoder.
module rld_ctrl import rld_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  rld_sts_t sts_i,
  output rld_cmd_t cmd_o
);

  localparam logic [1:0] ST_CONTROL = 2'd0;
  localparam logic [1:0] ST_REPEAT  = 2'd1;
  localparam logic [1:0] ST_LITERAL = 2'd2;
  localparam logic [1:0] ST_EMIT    = 2'd3;

  logic [1:0] state_q, state_d;
  logic       accept;

  assign in_ready_o = sts_i.slot_free && (state_q != ST_EMIT);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_CONTROL: begin
        if (accept) begin
          cmd_o.load_count = 1'b1;
          if (sts_i.byte_repeat) begin
            state_d = ST_REPEAT;
          end else if (!sts_i.byte_count_zero) begin
            state_d = ST_LITERAL;
          end
        end
      end
      ST_REPEAT: begin
        if (accept) begin
          if (sts_i.rem_zero) begin
            state_d = ST_CONTROL;
          end else begin
            cmd_o.load_value = 1'b1;
            state_d = ST_EMIT;
          end
        end
      end
      ST_LITERAL: begin
        if (accept) begin
          cmd_o.push_literal = 1'b1;
          if (sts_i.rem_is_one) begin
            state_d = ST_CONTROL;
          end
        end
      end
      ST_EMIT: begin
        if (sts_i.slot_free) begin
          cmd_o.push_repeat = 1'b1;
          if (sts_i.rem_is_one) begin
            state_d = ST_CONTROL;
          end
        end
      end
      default: begin
        state_d = ST_CONTROL;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CONTROL;
    end else begin
      state_q <= state_d;
    end
  end

  // A stalled emit run stays put until the output register frees up.
  a_emit_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) && !sts_i.slot_free |=> (state_q == ST_EMIT))
    else $error("emit run left while output was stalled");

  // A repeat value with a nonzero count always starts an emit run.
  a_repeat_to_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_REPEAT) && accept && !sts_i.rem_zero |=> (state_q == ST_EMIT))
    else $error("repeat value did not start an emit run");

endmodule

[rtl/rld_dp.sv]
// Datapath of the run-length decoder: counters, running total and output register.
module rld_dp import rld_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rld_cmd_t           cmd_i,
  output rld_sts_t           sts_o,
  input  logic [BYTE_W-1:0]  in_byte_i,
  input  logic               cfg_valid_i,
  input  logic [TOTAL_W-1:0] cfg_data_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic [BYTE_W-1:0]  out_byte_o,
  output logic               out_last_o,
  output logic               out_done_o
);

  logic [COUNT_W-1:0] rem_q, rem_d;
  logic [BYTE_W-1:0]  value_q;
  logic [TOTAL_W-1:0] total_q, total_d, total_inc;
  logic [TOTAL_W-1:0] cells_q;
  logic               out_valid_q;
  logic [BYTE_W-1:0]  out_byte_q;
  logic               out_last_q;
  logic               out_done_q;
  logic               push;
  logic               done;

  assign push = cmd_i.push_literal || cmd_i.push_repeat;

  assign sts_o.slot_free       = !out_valid_q || out_ready_i;
  assign sts_o.byte_repeat     = in_byte_i[REPEAT_BIT];
  assign sts_o.byte_count_zero = (in_byte_i[COUNT_W-1:0] == '0);
  assign sts_o.rem_zero        = (rem_q == '0);
  assign sts_o.rem_is_one      = (rem_q == COUNT_W'(1));

  // The total saturates; the image check runs on the final byte of a run.
  assign total_inc = (total_q == TOTAL_MAX) ? TOTAL_MAX : total_q + TOTAL_W'(1);
  assign done      = push && sts_o.rem_is_one && (total_inc >= cells_q);

  always_comb begin
    rem_d   = rem_q;
    total_d = total_q;
    if (cmd_i.load_count) begin
      rem_d = in_byte_i[COUNT_W-1:0];
    end else if (cmd_i.load_value) begin
      rem_d = (rem_q > RESULT_LIMIT) ? RESULT_LIMIT : rem_q;
    end else if (push) begin
      rem_d = rem_q - COUNT_W'(1);
    end
    if (push) begin
      total_d = done ? '0 : total_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q       <= '0;
      total_q     <= '0;
      cells_q     <= TOTAL_CELLS_RESET;
      out_valid_q <= 1'b0;
    end else begin
      rem_q   <= rem_d;
      total_q <= total_d;
      if (cfg_valid_i) begin
        cells_q <= cfg_data_i;
      end
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_value) begin
      value_q <= in_byte_i;
    end
    if (push) begin
      out_byte_q <= cmd_i.push_literal ? in_byte_i : value_q;
      out_last_q <= cmd_i.push_literal || sts_o.rem_is_one;
      out_done_q <= done;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;
  assign out_done_o  = out_done_q;

  a_no_push_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !out_valid_q || out_ready_i)
    else $error("byte pushed into an occupied output register");

  a_repeat_has_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push_repeat |-> (rem_q != '0) && (rem_q <= RESULT_LIMIT))
    else $error("repeat byte emitted with an invalid count");

  a_done_clears_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |=> (total_q == '0) && out_valid_q && out_done_q && out_last_q)
    else $error("image end did not clear the total or mark the last byte");

endmodule

[rtl/rle_control_byte_decoder.sv]
// Run-length control byte decoder, top level.
//
// This block expands a run-length coded byte stream. A control byte carries
// a 7-bit count in its low bits and produces no output. With bit 7 set, the
// next byte is a repeat value that is sent out min(count, 64) times; with
// bit 7 clear, the next count bytes are literals that are each sent out
// once. A zero count with bit 7 clear makes the next byte a control byte
// again; a zero count with bit 7 set swallows the following value byte.
// Every decoded byte carries last on the final byte caused by its input
// transfer, and image_done on the final byte of a run that brings the running
// total to or past total_cells, after which the total restarts at zero. The
// total saturates at 17 bits. total_cells resets to 4096 and is written
// through the configuration channel, which is always ready; write it only
// while the decoder is idle. Timing: control bytes and literal bytes stream
// at one transfer per cycle when the output side keeps up. A repeat value
// with count N is accepted and then occupies the decoder while its min(N, 64)
// bytes are sent through a single output register, one byte per cycle while
// the receiver keeps up; the input is held off during that emission. The
// output register holds one decoded byte, and while that byte waits to be
// taken the input is held off as well, control bytes included, so a stalled
// receiver stalls the sender in the same cycle.
module rle_control_byte_decoder import rld_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  rld_in_if.sink    in_i,
  rld_out_if.source out_o,
  rld_cfg_if.sink   cfg_i
);

  rld_cmd_t cmd;
  rld_sts_t sts;

  // The configuration register takes a write in any cycle.
  assign cfg_i.ready = 1'b1;

  // Phase sequencing: control byte, repeat value, literals, repeat emission.
  rld_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Counters, running total, image check and the output register.
  rld_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_byte_i   (in_i.in_byte),
    .cfg_valid_i (cfg_i.valid),
    .cfg_data_i  (cfg_i.total_cells),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .out_byte_o  (out_o.out_byte),
    .out_last_o  (out_o.last),
    .out_done_o  (out_o.image_done)
  );

endmodule
